// ----- hw/rtl/rasi_pkg.sv -----
// ============================================================================
// rasi_pkg: shared types and constants of the ray versus box slab test
// Field widths, divider depth and the sideband records passed between stages.
// ============================================================================
package rasi_pkg;

   localparam int NUM_W   = 32;            // Q16.16 input field width
   localparam int AXES    = 3;
   localparam int LANES   = 2 * AXES;      // one division per box face
   localparam int FRAC_W  = 16;
   localparam int MAG_W   = NUM_W + 1;     // magnitude of a 33-bit difference
   localparam int QUO_W   = MAG_W + FRAC_W; // dividend and quotient width
   localparam int REM_W   = NUM_W;         // remainder stays below the divisor
   localparam int T_W     = QUO_W + 2;     // signed slab parameter
   localparam int DIST_W  = 31;
   localparam int THR_W   = 16;
   localparam int REQ_W   = 12 * NUM_W;
   localparam int RSP_W   = 32;

   localparam logic signed [T_W-1:0] T_INF    = T_W'(64'sd1 <<< (T_W - 2));
   localparam logic signed [T_W-1:0] DIST_MAX = T_W'(64'sh7FFF_FFFF);

   localparam logic [1:0]       ADDR_THRESHOLD = 2'd0;
   localparam logic [THR_W-1:0] THR_RESET      = THR_W'(1);

   typedef logic [MAG_W-1:0]           mag_type;
   typedef logic [NUM_W-1:0]           den_type;
   typedef logic [QUO_W-1:0]           quo_type;
   typedef logic [REM_W-1:0]           rem_type;
   typedef logic signed [T_W-1:0]      t_type;

   // Per-axis flags travelling beside the divider lanes.
   typedef struct packed {
      logic [AXES-1:0]  par;     // axis counts as parallel
      logic [AXES-1:0]  in_slab; // origin within the slab of that axis
      logic [LANES-1:0] neg;     // quotient of that lane is negative
   } side_type;

endpackage

// ----- hw/rtl/rasi_csr.sv -----
// ============================================================================
// rasi_csr: configuration register port
// Holds the parallel threshold, written and read over a simple APB port.
// ============================================================================
module rasi_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [1:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output logic [rasi_pkg::THR_W-1:0] threshold
);
   import rasi_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             wr_en;

   // The port decodes a single word, so every byte offset selects it.
   assign wr_en  = psel && penable && pwrite && (paddr[1:0] == ADDR_THRESHOLD || 1'b1);
   assign thr_in = wr_en ? pwdata[THR_W-1:0] : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign pready    = 1'b1;
   assign prdata    = {{(32-THR_W){1'b0}}, thr_ff};
   assign threshold = thr_ff;

endmodule

// ----- hw/rtl/rasi_front.sv -----
// ============================================================================
// rasi_front: slab set-up stage
// Forms bound differences, magnitudes, signs and the parallel and inside flags.
// ============================================================================
module rasi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rasi_pkg::REQ_W-1:0]    in_data,
   input  logic [rasi_pkg::THR_W-1:0]    threshold,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rasi_pkg::mag_type             num [rasi_pkg::LANES],
   output rasi_pkg::den_type             den [rasi_pkg::AXES],
   output rasi_pkg::side_type            side
);
   import rasi_pkg::*;

   logic     v_ff, v_in, en;
   mag_type  num_ff [LANES];
   mag_type  num_in [LANES];
   den_type  den_ff [AXES];
   den_type  den_in [AXES];
   side_type side_ff, side_in;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;
   assign v_in     = en ? in_valid : v_ff;

   always_comb begin
      logic signed [NUM_W-1:0] org, dir, bmin, bmax;
      logic signed [MAG_W-1:0] d_lo, d_hi, dir_x;
      logic [MAG_W-1:0]        dmag;
      side_in = '0;
      for (int a = 0; a < AXES; a++) begin
         org  = in_data[a*NUM_W +: NUM_W];
         dir  = in_data[(3+a)*NUM_W +: NUM_W];
         bmin = in_data[(6+a)*NUM_W +: NUM_W];
         bmax = in_data[(9+a)*NUM_W +: NUM_W];
         d_lo = MAG_W'(bmin) - MAG_W'(org);
         d_hi = MAG_W'(bmax) - MAG_W'(org);
         dir_x = MAG_W'(dir);
         dmag  = dir_x[MAG_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
         num_in[2*a]   = d_lo[MAG_W-1] ? MAG_W'(-d_lo) : MAG_W'(d_lo);
         num_in[2*a+1] = d_hi[MAG_W-1] ? MAG_W'(-d_hi) : MAG_W'(d_hi);
         den_in[a]     = dmag[NUM_W-1:0];
         side_in.neg[2*a]   = d_lo[MAG_W-1] ^ dir[NUM_W-1];
         side_in.neg[2*a+1] = d_hi[MAG_W-1] ^ dir[NUM_W-1];
         side_in.par[a]     = (dir == '0) || (dmag < MAG_W'(threshold));
         side_in.in_slab[a] = (org >= bmin) && (org <= bmax);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v_ff;
   assign num       = num_ff;
   assign den       = den_ff;
   assign side      = side_ff;

endmodule

// ----- hw/rtl/rasi_div.sv -----
// ============================================================================
// rasi_div: pipelined unsigned divider, six lanes
// Restoring division, one quotient bit per stage over the scaled numerators.
// ============================================================================
module rasi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rasi_pkg::mag_type     num [rasi_pkg::LANES],
   input  rasi_pkg::den_type     den [rasi_pkg::AXES],
   input  rasi_pkg::side_type    side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rasi_pkg::quo_type     quo [rasi_pkg::LANES],
   output rasi_pkg::side_type    out_side
);
   import rasi_pkg::*;

   localparam int S = QUO_W;

   logic     v_ff    [1:S];
   logic     en      [1:S+1];
   rem_type  rem_ff  [1:S][LANES];
   quo_type  sh_ff   [1:S][LANES];   // dividend bits still to be brought down
   quo_type  quo_ff  [1:S][LANES];
   den_type  den_ff  [1:S][AXES];
   side_type side_ff [1:S];

   assign en[S+1]  = out_ready;
   assign in_ready = en[1];

   for (genvar s = 1; s <= S; s++) begin : g_stage
      logic     v_prev, v_in;
      rem_type  rem_prev [LANES];
      quo_type  quo_prev [LANES];
      quo_type  sh_prev  [LANES];
      den_type  den_prev [AXES];
      side_type side_prev;
      rem_type  rem_in [LANES];
      quo_type  quo_in [LANES];
      quo_type  sh_in  [LANES];

      // The first stage starts from the scaled numerators and a zero remainder.
      if (s == 1) begin : g_head
         always_comb begin
            v_prev    = in_valid;
            side_prev = side;
            for (int l = 0; l < LANES; l++) begin
               rem_prev[l] = '0;
               quo_prev[l] = '0;
               sh_prev[l]  = {num[l], {FRAC_W{1'b0}}};
            end
            for (int a = 0; a < AXES; a++) begin
               den_prev[a] = den[a];
            end
         end
      end else begin : g_tail
         always_comb begin
            v_prev    = v_ff[s-1];
            side_prev = side_ff[s-1];
            rem_prev  = rem_ff[s-1];
            quo_prev  = quo_ff[s-1];
            sh_prev   = sh_ff[s-1];
            den_prev  = den_ff[s-1];
         end
      end

      assign en[s] = !v_ff[s] || en[s+1];
      assign v_in  = en[s] ? v_prev : v_ff[s];

      always_comb begin
         logic [REM_W:0] cat;
         logic [REM_W:0] dz;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            cat = {rem_prev[l], sh_prev[l][QUO_W-1]};
            dz  = {1'b0, den_prev[l/2]};
            ge  = cat >= dz;
            rem_in[l] = ge ? REM_W'(cat - dz) : cat[REM_W-1:0];
            quo_in[l] = {quo_prev[l][QUO_W-2:0], ge};
            sh_in[l]  = {sh_prev[l][QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            sh_ff[s]   <= sh_in;
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[S];
   assign quo       = quo_ff[S];
   assign out_side  = side_ff[S];

endmodule

// ----- hw/rtl/rasi_back.sv -----
// ============================================================================
// rasi_back: interval intersection and result stages
// Signs the slab parameters, intersects the axis intervals, forms the result.
// ============================================================================
module rasi_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rasi_pkg::quo_type     quo [rasi_pkg::LANES],
   input  rasi_pkg::side_type    side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  hit,
   output logic [rasi_pkg::DIST_W-1:0] distance
);
   import rasi_pkg::*;

   logic            v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   logic            en1, en2, en3;
   t_type           tmin_ff [AXES];
   t_type           tmax_ff [AXES];
   t_type           tmin_in [AXES];
   t_type           tmax_in [AXES];
   logic [AXES-1:0] par_ff, pmiss_ff;
   t_type           lo_ff, hi_ff, lo_in, hi_in;
   logic            miss_ff, miss_in;
   logic            hit_ff, hit_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign v1_in    = en1 ? in_valid : v1_ff;
   assign v2_in    = en2 ? v1_ff : v2_ff;
   assign v3_in    = en3 ? v2_ff : v3_ff;

   // Stage one: apply signs and order each axis pair.
   always_comb begin
      t_type t0, t1, m0, m1;
      for (int a = 0; a < AXES; a++) begin
         m0 = t_type'({2'b00, quo[2*a]});
         m1 = t_type'({2'b00, quo[2*a+1]});
         t0 = side.neg[2*a]   ? -m0 : m0;
         t1 = side.neg[2*a+1] ? -m1 : m1;
         tmin_in[a] = (t0 > t1) ? t1 : t0;
         tmax_in[a] = (t0 > t1) ? t0 : t1;
      end
   end

   // Stage two: intersect the intervals of the non-parallel axes.
   always_comb begin
      lo_in = -T_INF;
      hi_in = T_INF;
      for (int a = 0; a < AXES; a++) begin
         if (!par_ff[a]) begin
            if (tmin_ff[a] > lo_in) begin
               lo_in = tmin_ff[a];
            end
         end
      end
      for (int a = 0; a < AXES; a++) begin
         if (!par_ff[a]) begin
            if (tmax_ff[a] < hi_in) begin
               hi_in = tmax_ff[a];
            end
         end
      end
   end

   assign miss_in = (|pmiss_ff) || (lo_in > hi_in) || hi_in[T_W-1];

   // Stage three: pick the entry, or the exit when the origin is inside.
   always_comb begin
      t_type d;
      d       = lo_ff[T_W-1] ? hi_ff : lo_ff;
      hit_in  = !miss_ff;
      if (miss_ff) begin
         dist_in = '0;
      end else if (d > DIST_MAX) begin
         dist_in = DIST_MAX[DIST_W-1:0];
      end else begin
         dist_in = d[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         tmin_ff  <= tmin_in;
         tmax_ff  <= tmax_in;
         par_ff   <= side.par;
         pmiss_ff <= side.par & ~side.in_slab;
      end
      if (en2) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         miss_ff <= miss_in;
      end
      if (en3) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign out_valid = v3_ff;
   assign hit       = hit_ff;
   assign distance  = dist_ff;

endmodule

// ----- hw/rtl/ray_aabb_slab_intersect.sv -----
// ============================================================================
// ray_aabb_slab_intersect: ray versus axis-aligned box, three-axis slab test
// Streams one ray and box per request and returns a hit flag and distance.
// ============================================================================
// One request enters per clock cycle unless a stall holds the pipeline, and
// passes one set-up stage, 49 divider stages, three intersection and result
// stages. The depth is set by the six restoring dividers, which resolve one
// quotient bit per stage. All stages stall together only where a stage holds
// data that cannot move on; empty stages keep filling while the response waits.
// ============================================================================
module ray_aabb_slab_intersect (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // box_min_x/y/z, box_max_x/y/z, 32 bits each
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit [0], distance [31:1]
   output logic [31:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rasi_pkg::*;

   logic [THR_W-1:0] threshold;
   logic             f_valid, f_ready, d_valid, d_ready;
   mag_type          f_num [LANES];
   den_type          f_den [AXES];
   side_type         f_side, d_side;
   quo_type          d_quo [LANES];
   logic             hit;
   logic [DIST_W-1:0] distance;

   rasi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .threshold (threshold)
   );

   rasi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .threshold (threshold),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .num       (f_num),
      .den       (f_den),
      .side      (f_side)
   );

   rasi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .num       (f_num),
      .den       (f_den),
      .side      (f_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .quo       (d_quo),
      .out_side  (d_side)
   );

   rasi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .quo       (d_quo),
      .side      (d_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hit       (hit),
      .distance  (distance)
   );

   assign rsp_tdata = {distance, hit};

endmodule

// ----- hw/rtl/rasi_checker.sv -----
// ============================================================================
// rasi_checker: port-level checks for the slab test block
// Watches the response channel and the register port over time.
// ============================================================================
module rasi_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite,
   input logic [31:0]  csr_pwdata,
   input logic [31:0]  csr_prdata
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A miss carries a zero distance.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[31:1] == 31'd0)
      else $error("miss with nonzero distance");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response offered straight after reset");

   // A threshold write reads back once it is registered.
   a_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=>
         csr_prdata == {16'd0, $past(csr_pwdata[15:0])})
      else $error("threshold readback mismatch");

endmodule

bind ray_aabb_slab_intersect rasi_checker u_rasi_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

// ----- test/ray_aabb_slab_intersect_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ray_aabb_slab_intersect_test: self-checking bench for the slab intersector
// Drives directed and random ray and box requests, at random pacing but for one
// calm pass; predicts hit and distance for each, compares every response in order.
// ============================================================================
module ray_aabb_slab_intersect_test;
   import rasi_pkg::*;

   typedef struct packed {
      logic [31:0] bmax_z, bmax_y, bmax_x, bmin_z, bmin_y, bmin_x;
      logic [31:0] dir_z, dir_y, dir_x, org_z, org_y, org_x;
   } ray_box_t;

   typedef struct packed {
      logic [30:0] distance;
      logic        hit;
   } hit_t;

   typedef struct {
      ray_box_t    rb;
      logic        known;
      hit_t        res;
   } row_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [1:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic [15:0]  threshold;
   hit_t         pending_hits[$];
   int           fail_count;
   int           idle_cycles;
   bit           calm;

   ray_aabb_slab_intersect DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic hit_t slab_hit(ray_box_t rb, logic [15:0] thr);
      logic signed [63:0] lo, hi, org, dir, bmin, bmax, mag, t1, t2, tmp, d;
      logic [31:0] o[3], dv[3], mn[3], mx[3];
      bit   miss;
      hit_t r;
      o  = '{rb.org_x, rb.org_y, rb.org_z};
      dv = '{rb.dir_x, rb.dir_y, rb.dir_z};
      mn = '{rb.bmin_x, rb.bmin_y, rb.bmin_z};
      mx = '{rb.bmax_x, rb.bmax_y, rb.bmax_z};
      lo = -(64'sd1 <<< 62);
      hi = 64'sd1 <<< 62;
      miss = 0;
      for (int a = 0; a < 3 && !miss; a++) begin
         org  = signed'(o[a]);
         dir  = signed'(dv[a]);
         bmin = signed'(mn[a]);
         bmax = signed'(mx[a]);
         mag  = dir < 0 ? -dir : dir;
         if (dir == 0 || mag < signed'({48'd0, thr})) begin
            if (org < bmin || org > bmax) miss = 1;
         end else begin
            t1 = ((bmin - org) * 64'sd65536) / dir;
            t2 = ((bmax - org) * 64'sd65536) / dir;
            if (t1 > t2) begin
               tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > lo) lo = t1;
            if (t2 < hi) hi = t2;
            if (lo > hi) miss = 1;
         end
      end
      if (!miss && hi < 0) miss = 1;
      r = '0;
      if (!miss) begin
         d = (lo >= 0) ? lo : hi;
         if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
         r.hit = 1'b1;
         r.distance = d[30:0];
      end
      return r;
   endfunction

   // Random field: mostly small coordinates, sometimes extremes or full range.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return 32'($signed($urandom_range(4000)) - 2000);
         default: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
      endcase
   endfunction

   function automatic ray_box_t rand_ray_box();
      ray_box_t rb;
      logic [31:0] a, b;
      rb = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(9) == 0) return rb;
      rb.org_x = rand_coord(); rb.org_y = rand_coord(); rb.org_z = rand_coord();
      rb.dir_x = rand_coord(); rb.dir_y = rand_coord(); rb.dir_z = rand_coord();
      if ($urandom_range(3) == 0) rb.dir_y = $urandom_range(3) - 1;
      if ($urandom_range(5) == 0) rb.dir_z = 32'($urandom_range(2000));
      a = rand_coord(); b = rand_coord();
      if ($urandom_range(7) != 0 && $signed(a) > $signed(b)) begin
         rb.bmin_x = b; rb.bmax_x = a;
      end else begin
         rb.bmin_x = a; rb.bmax_x = b;
      end
      a = rand_coord(); b = rand_coord();
      rb.bmin_y = $signed(a) < $signed(b) ? a : b;
      rb.bmax_y = $signed(a) < $signed(b) ? b : a;
      a = rand_coord(); b = rand_coord();
      rb.bmin_z = $signed(a) < $signed(b) ? a : b;
      rb.bmax_z = $signed(a) < $signed(b) ? b : a;
      return rb;
   endfunction

   task automatic send_request(ray_box_t rb);
      req_tvalid <= 1'b1;
      req_tdata  <= rb;
      do @(posedge clock); while (!req_tready);
      pending_hits.push_back(slab_hit(rb, threshold));
      if (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_THRESHOLD;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      threshold = value;
      @(posedge clock);
   endtask

   // Responses are compared against the oldest prediction still waiting.
   always @(posedge clock) begin
      hit_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_hits.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, got.hit);
               fail_count++;
            end
            if (got.distance !== want.distance) begin
               $error("distance: expected %h, got %h", want.distance, got.distance);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 26);
   end

   // Watchdog on cycles without any accepted request or response.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      row_t        rows[$];
      row_t        row;
      ray_box_t    rb;
      logic [15:0] settings[4];
      hit_t        h;
      fail_count  = 0;
      idle_cycles = 0;
      calm        = 0;
      threshold   = THR_RESET;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unit box from 0 to 1 on every axis.
      rb = '0;
      rb.bmax_x = 32'h10000; rb.bmax_y = 32'h10000; rb.bmax_z = 32'h10000;
      // All axes parallel, origin inside: distance saturates.
      row.rb = rb; row.known = 1; h.hit = 1; h.distance = 31'h7FFFFFFF; row.res = h;
      rows.push_back(row);
      // Parallel axis with origin outside the slab misses.
      row.rb = rb; row.rb.org_x = 32'h20000; row.known = 1; row.res = '0;
      rows.push_back(row);
      // Ray along +x from -2: entry at 2.0.
      row.rb = rb; row.rb.org_x = 32'hFFFE0000; row.rb.org_y = 32'h8000;
      row.rb.org_z = 32'h8000; row.rb.dir_x = 32'h10000; row.known = 1;
      h.hit = 1; h.distance = 31'h20000; row.res = h;
      rows.push_back(row);
      // Pointing away: interval ends before zero.
      row.rb.dir_x = 32'hFFFF0000; row.known = 1; row.res = '0;
      rows.push_back(row);
      // Origin inside, moving +x: exit distance 0.5.
      row.rb = rb; row.rb.org_x = 32'h8000; row.rb.org_y = 32'h8000;
      row.rb.org_z = 32'h8000; row.rb.dir_x = 32'h10000; row.known = 1;
      h.hit = 1; h.distance = 31'h8000; row.res = h;
      rows.push_back(row);
      // Inverted box, parallel axes: miss.
      row.rb = '0; row.rb.bmin_x = 32'h10000; row.known = 1; row.res = '0;
      rows.push_back(row);
      row.known = 0;
      // Minimum direction, extremes of bounds, tiny directions.
      row.rb = rb; row.rb.dir_x = 32'h80000000; row.rb.bmin_x = 32'h80000000;
      row.rb.bmax_x = 32'h7FFFFFFF; rows.push_back(row);
      row.rb = '1; row.rb.dir_x = 32'h7FFFFFFF; rows.push_back(row);
      row.rb = {12{32'h80000000}}; rows.push_back(row);
      row.rb = {12{32'h7FFFFFFF}}; rows.push_back(row);
      row.rb = rb; row.rb.dir_x = 32'h1; row.rb.dir_y = 32'hFFFFFFFF;
      row.rb.org_x = 32'hFFFF0000; rows.push_back(row);
      row.rb = rb; row.rb.org_x = 32'h80000000; row.rb.dir_x = 32'h7FFFFFFF;
      row.rb.bmax_x = 32'h7FFFFFFF; rows.push_back(row);
      row.rb = rb; row.rb.org_z = 32'h7FFFFFFF; row.rb.dir_z = 32'h80000000;
      row.rb.bmin_z = 32'h80000000; rows.push_back(row);

      foreach (rows[i]) begin
         send_request(rows[i].rb);
         if (rows[i].known) begin
            if (pending_hits[$].hit !== rows[i].res.hit) begin
               $error("row %0d hit: expected %0d, got %0d", i, rows[i].res.hit,
                      pending_hits[$].hit);
               fail_count++;
            end
            if (pending_hits[$].distance !== rows[i].res.distance) begin
               $error("row %0d distance: expected %h, got %h", i,
                      rows[i].res.distance, pending_hits[$].distance);
               fail_count++;
            end
         end
      end

      // Sender holds off until everything is back, then thresholds are stepped.
      drain();
      settings = '{16'd0, 16'hFFFF, 16'd1000, 16'd1};
      foreach (settings[s]) begin
         write_threshold(settings[s]);
         calm = (s == 2);
         for (int n = 0; n < 350; n++) send_request(rand_ray_box());
         calm = 0;
         drain();
      end

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
